[hw/rtl/jqps_pkg.sv]
package jqps_pkg;

  // one stored job record
  typedef struct packed {
    logic [15:0] tag;
    logic [47:0] arr;
    logic [15:0] cpu;
    logic [7:0]  pri;
    logic [1:0]  st;
  } rec_t;

  typedef struct packed {
    logic [15:0] job_tag;
    logic [47:0] arrival_us;
    logic [15:0] cpu_ticks;
    logic [7:0]  priority_req;
    logic [1:0]  job_status;
    logic        last_record;
  } in_word_t;

  typedef struct packed {
    logic [15:0] out_tag;
    logic [47:0] out_arrival_us;
    logic [15:0] out_cpu_ticks;
    logic [7:0]  out_priority;
    logic [1:0]  out_status;
    logic        out_last;
  } out_word_t;

  localparam logic [1:0] ST_WAITING = 2'd0;

  localparam logic [1:0] POL_ARRIVAL  = 2'd0;
  localparam logic [1:0] POL_CPU      = 2'd1;
  localparam logic [1:0] POL_PRIORITY = 2'd2;

  typedef enum logic [1:0] {
    RD_I  = 2'd0,
    RD_I1 = 2'd1,
    RD_J1 = 2'd2,
    RD_K  = 2'd3
  } rd_sel_t;

  typedef enum logic [6:0] {
    S_LOAD    = 7'b0000001,
    S_PASS    = 7'b0000010,
    S_LDI     = 7'b0000100,
    S_CMP     = 7'b0001000,
    S_WB      = 7'b0010000,
    S_EMIT_RD = 7'b0100000,
    S_EMIT_LD = 7'b1000000
  } state_t;

  typedef struct packed {
    logic    load_wr;
    logic    cnt_inc;
    logic    cnt_clr;
    logic    i_clr;
    logic    i_inc;
    logic    j_set;
    logic    j_inc;
    logic    k_clr;
    logic    k_inc;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    reci_load;
    logic    cmp_en;
    logic    wb;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic count_full;
    logic i_last;
    logic j_last;
    logic j_first;
    logic rd_waiting;
    logic out_free;
    logic k_last;
  } stat_t;

endpackage

[hw/rtl/jqps_ctrl.sv]
module jqps_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_last,
  output logic            in_stall,
  input  jqps_pkg::stat_t stat,
  output jqps_pkg::cmd_t  cmd
);

  jqps_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jqps_pkg::S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != jqps_pkg::S_LOAD);

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = jqps_pkg::RD_I;
    state_next = state;
    case (state)
      jqps_pkg::S_LOAD: begin
        if (in_valid) begin
          cmd.load_wr = !stat.count_full;
          cmd.cnt_inc = !stat.count_full;
          if (in_last) begin
            cmd.i_clr  = 1'b1;
            state_next = jqps_pkg::S_PASS;
          end
        end
      end
      jqps_pkg::S_PASS: begin
        if (stat.i_last) begin
          cmd.k_clr  = 1'b1;
          state_next = jqps_pkg::S_EMIT_RD;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = jqps_pkg::RD_I;
          state_next = jqps_pkg::S_LDI;
        end
      end
      jqps_pkg::S_LDI: begin
        cmd.reci_load = 1'b1;
        cmd.j_set     = 1'b1;
        cmd.rd_en     = 1'b1;
        cmd.rd_sel    = jqps_pkg::RD_I1;
        state_next    = jqps_pkg::S_CMP;
      end
      jqps_pkg::S_CMP: begin
        if (!stat.rd_waiting) begin
          if (stat.j_first) begin
            cmd.k_clr  = 1'b1;
            state_next = jqps_pkg::S_EMIT_RD;
          end else begin
            state_next = jqps_pkg::S_WB;
          end
        end else begin
          cmd.cmp_en = 1'b1;
          if (stat.j_last) begin
            state_next = jqps_pkg::S_WB;
          end else begin
            cmd.j_inc  = 1'b1;
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = jqps_pkg::RD_J1;
          end
        end
      end
      jqps_pkg::S_WB: begin
        cmd.wb     = 1'b1;
        cmd.i_inc  = 1'b1;
        state_next = jqps_pkg::S_PASS;
      end
      jqps_pkg::S_EMIT_RD: begin
        if (stat.out_free) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = jqps_pkg::RD_K;
          state_next = jqps_pkg::S_EMIT_LD;
        end
      end
      jqps_pkg::S_EMIT_LD: begin
        cmd.out_load = 1'b1;
        cmd.k_inc    = 1'b1;
        if (stat.k_last) begin
          cmd.cnt_clr = 1'b1;
          state_next  = jqps_pkg::S_LOAD;
        end else begin
          state_next = jqps_pkg::S_EMIT_RD;
        end
      end
      default: begin
        state_next = jqps_pkg::S_LOAD;
      end
    endcase
  end

endmodule

[hw/rtl/jqps_dpath.sv]
module jqps_dpath #(
  parameter int MAX_JOBS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_wdata,
  input  jqps_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output jqps_pkg::out_word_t out_word,
  input  jqps_pkg::cmd_t      cmd,
  output jqps_pkg::stat_t     stat
);

  localparam int AW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CW = $clog2(MAX_JOBS + 1);

  jqps_pkg::rec_t mem [MAX_JOBS];

  logic [CW-1:0]  count;
  logic [AW-1:0]  i, j, k;
  logic [1:0]     policy;
  jqps_pkg::rec_t rec_i, rdata, in_rec;
  logic [AW-1:0]  rd_addr, wr_addr;
  jqps_pkg::rec_t wr_data;
  logic           wr_en;
  logic           swap;

  assign in_rec = '{tag: in_word.job_tag, arr: in_word.arrival_us,
                    cpu: in_word.cpu_ticks, pri: in_word.priority_req,
                    st: in_word.job_status};

  // swap decision for record i against record j
  always_comb begin
    case (policy)
      jqps_pkg::POL_ARRIVAL:  swap = rec_i.arr < rdata.arr;
      jqps_pkg::POL_CPU:      swap = rec_i.cpu < rdata.cpu;
      jqps_pkg::POL_PRIORITY: swap = rec_i.pri > rdata.pri;
      default:                swap = 1'b0;
    endcase
  end

  always_comb begin
    case (cmd.rd_sel)
      jqps_pkg::RD_I:  rd_addr = i;
      jqps_pkg::RD_I1: rd_addr = i + AW'(1);
      jqps_pkg::RD_J1: rd_addr = j + AW'(1);
      jqps_pkg::RD_K:  rd_addr = k;
      default:         rd_addr = i;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = i;
    wr_data = rec_i;
    if (cmd.load_wr) begin
      wr_en   = 1'b1;
      wr_addr = AW'(count);
      wr_data = in_rec;
    end else if (cmd.cmp_en && swap) begin
      wr_en   = 1'b1;
      wr_addr = j;
      wr_data = rec_i;
    end else if (cmd.wb) begin
      wr_en   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.reci_load) begin
      rec_i <= rdata;
    end else if (cmd.cmp_en && swap) begin
      rec_i <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      i      <= '0;
      j      <= '0;
      k      <= '0;
      policy <= jqps_pkg::POL_ARRIVAL;
    end else begin
      if (cfg_we) begin
        policy <= cfg_wdata;
      end
      if (cmd.cnt_clr) begin
        count <= '0;
      end else if (cmd.cnt_inc) begin
        count <= count + CW'(1);
      end
      if (cmd.i_clr) begin
        i <= '0;
      end else if (cmd.i_inc) begin
        i <= i + AW'(1);
      end
      if (cmd.j_set) begin
        j <= i + AW'(1);
      end else if (cmd.j_inc) begin
        j <= j + AW'(1);
      end
      if (cmd.k_clr) begin
        k <= '0;
      end else if (cmd.k_inc) begin
        k <= k + AW'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_word <= '{out_tag: rdata.tag, out_arrival_us: rdata.arr,
                    out_cpu_ticks: rdata.cpu, out_priority: rdata.pri,
                    out_status: rdata.st, out_last: stat.k_last};
    end
  end

  assign stat.count_full = (count == CW'(MAX_JOBS));
  assign stat.i_last     = ((CW'(i) + CW'(1)) >= count);
  assign stat.j_last     = ((CW'(j) + CW'(1)) >= count);
  assign stat.j_first    = (j == (i + AW'(1)));
  assign stat.rd_waiting = (rdata.st == jqps_pkg::ST_WAITING);
  assign stat.out_free   = !out_valid || !out_stall;
  assign stat.k_last     = ((CW'(k) + CW'(1)) == count);

endmodule

[hw/rtl/job_queue_policy_sort_core.sv]
// job list sorter: loads job records, sorts the leading waiting run by policy, emits them
// input channel: one record word per accepted cycle (in_valid high, in_stall low);
//   the word with last_record set closes the list and starts the sort
// records beyond MAX_JOBS are dropped, a dropped last word still closes the list
// sort_policy is written through cfg_we / cfg_wdata; the user writes it only while the
//   block is idle, which the block itself does not enforce:
//   0 latest arrival first, 1 larger cpu time first, 2 smaller priority first, 3 no reorder
// in_stall stays high from the last word until the final result has been loaded into
//   the output register
// sort time is set by the record memory (one read port, one write port) and one shared
//   comparator: each pass holds record i, compares it with each following waiting record,
//   keeps the winner and writes it back to position i
// emission: a memory read then an output register load per result word; out_last marks the
//   final record; a stall from the receiver holds the output word and pauses emission only
// reset: empties the list, sets sort_policy to 0, clears out_valid
module job_queue_policy_sort_core #(
  parameter int MAX_JOBS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  jqps_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output jqps_pkg::out_word_t out_word
);

  // command and status between controller and datapath
  jqps_pkg::cmd_t  cmd;
  jqps_pkg::stat_t stat;

  jqps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_last  (in_word.last_record),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // record memory, index counters, comparator and output register
  jqps_dpath #(
    .MAX_JOBS (MAX_JOBS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

[tb/job_queue_policy_sort_core_tb.sv]
module job_queue_policy_sort_core_tb;

  // block configuration and local codes not held in the package
  localparam int JOB_SLOTS = 64;
  localparam logic [1:0] POL_KEEP = 2'd3;
  localparam logic [1:0] ST_RUNNING = 2'd1;
  localparam logic [1:0] ST_FAILED = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;
  // cycles left after the final result before the block counts as idle
  localparam int IDLE_GUARD = 12;
  // length of the long receiver hold-off
  localparam int HOLD_CYCLES = 200;

  // every input known from time zero
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_wdata = 2'd0;
  logic in_valid = 1'b0;
  logic in_stall;
  jqps_pkg::in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  jqps_pkg::out_word_t out_word;

  // predictor state: records held for the current list and the active policy
  jqps_pkg::rec_t held_jobs [JOB_SLOTS];
  int held_count = 0;
  logic [1:0] active_policy = jqps_pkg::POL_ARRIVAL;
  // sorted words still to come out of the block, oldest first
  jqps_pkg::out_word_t expected_words [$];

  int mismatches = 0;
  // sender runs without gaps while this is set
  bit tx_quiet = 1'b0;
  // each increment asks the stall process for one long hold-off
  int hold_requests = 0;
  int hold_seen = 0;
  int stall_left = 0;
  int calm_left = 0;

  job_queue_policy_sort_core #(
    .MAX_JOBS(JOB_SLOTS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word(out_word)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  // swap rule of the exchange sort for the active policy
  function automatic bit jumps_ahead(jqps_pkg::rec_t a, jqps_pkg::rec_t b);
    case (active_policy)
      jqps_pkg::POL_ARRIVAL: begin
        return a.arr < b.arr;
      end
      jqps_pkg::POL_CPU: begin
        return a.cpu < b.cpu;
      end
      jqps_pkg::POL_PRIORITY: begin
        return a.pri > b.pri;
      end
      default: begin
        return 1'b0;
      end
    endcase
  endfunction

  // exchange sort over the leading waiting run; status is read where a record
  // sits at that moment, so a non-waiting record moved in from entry 0 stops the run
  function automatic void order_held_jobs();
    int i;
    int j;
    jqps_pkg::rec_t tmp;
    for (i = 0; i + 1 < held_count && held_jobs[i + 1].st == jqps_pkg::ST_WAITING;
         i++) begin
      for (j = i + 1; j < held_count && held_jobs[j].st == jqps_pkg::ST_WAITING;
           j++) begin
        if (jumps_ahead(held_jobs[i], held_jobs[j])) begin
          tmp = held_jobs[i];
          held_jobs[i] = held_jobs[j];
          held_jobs[j] = tmp;
        end
      end
    end
  endfunction

  // one accepted input word: store it unless full, and on the closing word
  // sort the list and queue every record as an expected output word
  function automatic void take_record(jqps_pkg::in_word_t w);
    jqps_pkg::out_word_t o;
    int k;
    if (held_count < JOB_SLOTS) begin
      held_jobs[held_count].tag = w.job_tag;
      held_jobs[held_count].arr = w.arrival_us;
      held_jobs[held_count].cpu = w.cpu_ticks;
      held_jobs[held_count].pri = w.priority_req;
      held_jobs[held_count].st = w.job_status;
      held_count++;
    end
    if (w.last_record) begin
      order_held_jobs();
      for (k = 0; k < held_count; k++) begin
        o.out_tag = held_jobs[k].tag;
        o.out_arrival_us = held_jobs[k].arr;
        o.out_cpu_ticks = held_jobs[k].cpu;
        o.out_priority = held_jobs[k].pri;
        o.out_status = held_jobs[k].st;
        o.out_last = (k == held_count - 1);
        expected_words.push_back(o);
      end
      held_count = 0;
    end
  endfunction

  function automatic jqps_pkg::in_word_t make_word(logic [15:0] tag, logic [47:0] arr,
                                                   logic [15:0] cpu, logic [7:0] pri,
                                                   logic [1:0] st, logic is_last);
    jqps_pkg::in_word_t w;
    w.job_tag = tag;
    w.arrival_us = arr;
    w.cpu_ticks = cpu;
    w.priority_req = pri;
    w.job_status = st;
    w.last_record = is_last;
    return w;
  endfunction

  // random record; narrow keys force plenty of ties between records
  function automatic jqps_pkg::in_word_t random_record(bit is_last, bit narrow);
    logic [63:0] wide;
    logic [1:0] st;
    wide = {$urandom(), $urandom()};
    st = ($urandom_range(0, 99) < 75) ? jqps_pkg::ST_WAITING : 2'($urandom_range(1, 3));
    if (narrow) begin
      return make_word(16'($urandom()), 48'($urandom_range(0, 3)),
                       16'($urandom_range(0, 3)), 8'($urandom_range(0, 3)), st, is_last);
    end
    return make_word(16'($urandom()), wide[47:0], 16'($urandom()), 8'($urandom()),
                     st, is_last);
  endfunction

  // mostly no gap, some short ones, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end
    if (r < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 30);
  endfunction

  // offer one word, hold it until accepted, then maybe leave a gap;
  // valid stays high when the next word follows straight away
  task automatic send_word(input jqps_pkg::in_word_t w);
    int gap;
    in_word <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    take_record(w);
    gap = tx_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // sender stops until every expected word is out and the block has gone idle
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (IDLE_GUARD) @(posedge clk);
  endtask

  // only called while idle
  task automatic write_policy(input logic [1:0] p);
    cfg_wdata <= p;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    active_policy = p;
  endtask

  task automatic send_random_list(input int len, input bit narrow);
    int k;
    for (k = 0; k < len; k++) begin
      send_word(random_record(k == len - 1, narrow));
    end
  endtask

  // receiver side: random stalls, calm stretches, and long hold-offs on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
      calm_left = 0;
    end else begin
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        stall_left = HOLD_CYCLES;
      end else if (stall_left > 0) begin
        stall_left--;
      end else if (calm_left > 0) begin
        calm_left--;
      end else if ($urandom_range(0, 99) < 3) begin
        calm_left = $urandom_range(40, 150);
      end else if ($urandom_range(0, 99) < 30) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50)
                                                 : $urandom_range(1, 3);
      end
      out_stall <= (stall_left > 0);
    end
  end

  task automatic note_mismatch(input bit unexpected, input jqps_pkg::out_word_t want,
                               input jqps_pkg::out_word_t got);
    mismatches++;
    if (mismatches <= 10) begin
      if (unexpected) begin
        $display("unexpected word: tag %h arr %h cpu %h pri %h st %0d last %0d",
                 got.out_tag, got.out_arrival_us, got.out_cpu_ticks,
                 got.out_priority, got.out_status, got.out_last);
      end else begin
        $display("mismatch: expected tag %h arr %h cpu %h pri %h st %0d last %0d",
                 want.out_tag, want.out_arrival_us, want.out_cpu_ticks,
                 want.out_priority, want.out_status, want.out_last);
        $display("          actual   tag %h arr %h cpu %h pri %h st %0d last %0d",
                 got.out_tag, got.out_arrival_us, got.out_cpu_ticks,
                 got.out_priority, got.out_status, got.out_last);
      end
    end
  endtask

  // output checker: each accepted word against the oldest expectation
  always @(posedge clk) begin
    jqps_pkg::out_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        note_mismatch(1'b1, '0, out_word);
      end else begin
        want = expected_words.pop_front();
        if (out_word.out_tag !== want.out_tag ||
            out_word.out_arrival_us !== want.out_arrival_us ||
            out_word.out_cpu_ticks !== want.out_cpu_ticks ||
            out_word.out_priority !== want.out_priority ||
            out_word.out_status !== want.out_status ||
            out_word.out_last !== want.out_last) begin
          note_mismatch(1'b0, want, out_word);
        end
      end
    end
  end

  // one-record lists at both ends of every field, under the reset policy
  task automatic test_single_records();
    send_word(make_word(16'hFFFF, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 8'hFF, ST_DONE, 1'b1));
    send_word(make_word(16'h0000, 48'h0, 16'h0000, 8'h00, jqps_pkg::ST_WAITING, 1'b1));
    settle();
  endtask

  // latest arrival first; keys differ in top and bottom bits, a running
  // record ends the sorted run and the waiting one after it keeps its place
  task automatic test_arrival_order();
    write_policy(jqps_pkg::POL_ARRIVAL);
    send_word(make_word(16'h0001, 48'h0000_0000_0001, 16'h0010, 8'h10,
                        jqps_pkg::ST_WAITING, 1'b0));
    send_word(make_word(16'h0002, 48'h8000_0000_0000, 16'h0020, 8'h20,
                        jqps_pkg::ST_WAITING, 1'b0));
    send_word(make_word(16'h0003, 48'h0, 16'h0030, 8'h30, jqps_pkg::ST_WAITING, 1'b0));
    send_word(make_word(16'h0004, 48'hFFFF_FFFF_FFFF, 16'h0040, 8'h40,
                        jqps_pkg::ST_WAITING, 1'b0));
    send_word(make_word(16'h0005, 48'h0000_0000_0002, 16'h0050, 8'h50, ST_RUNNING, 1'b0));
    send_word(make_word(16'h0006, 48'hFFFF_FFFF_FFFF, 16'h0060, 8'h60,
                        jqps_pkg::ST_WAITING, 1'b1));
    settle();
  endtask

  // larger cpu time first, with a tie and a failed record closing the run
  task automatic test_cpu_order();
    write_policy(jqps_pkg::POL_CPU);
    send_word(make_word(16'h0101, 48'h5, 16'h0000, 8'h01, jqps_pkg::ST_WAITING, 1'b0));
    send_word(make_word(16'h0102, 48'h6, 16'hFFFF, 8'h02, jqps_pkg::ST_WAITING, 1'b0));
    send_word(make_word(16'h0103, 48'h7, 16'hFFFF, 8'h03, jqps_pkg::ST_WAITING, 1'b0));
    send_word(make_word(16'h0104, 48'h8, 16'h8000, 8'h04, ST_FAILED, 1'b1));
    settle();
  endtask

  // smaller priority first; the done record at the end ties a waiting one and keeps its place
  task automatic test_priority_order();
    write_policy(jqps_pkg::POL_PRIORITY);
    send_word(make_word(16'h0201, 48'h1, 16'h1, 8'hFF, jqps_pkg::ST_WAITING, 1'b0));
    send_word(make_word(16'h0202, 48'h2, 16'h2, 8'h00, jqps_pkg::ST_WAITING, 1'b0));
    send_word(make_word(16'h0203, 48'h3, 16'h3, 8'h80, jqps_pkg::ST_WAITING, 1'b0));
    send_word(make_word(16'h0204, 48'h4, 16'h4, 8'h00, ST_DONE, 1'b1));
    settle();
  endtask

  // policy three leaves the order as loaded
  task automatic test_keep_order();
    write_policy(POL_KEEP);
    send_word(make_word(16'h0301, 48'h1, 16'h0001, 8'hFF, jqps_pkg::ST_WAITING, 1'b0));
    send_word(make_word(16'h0302, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 8'h00,
                        jqps_pkg::ST_WAITING, 1'b0));
    send_word(make_word(16'h0303, 48'h2, 16'h0002, 8'h7F, jqps_pkg::ST_WAITING, 1'b1));
    settle();
  endtask

  // entry 0 is running but still takes part and is carried to the end of the list
  task automatic test_busy_head();
    write_policy(jqps_pkg::POL_CPU);
    send_word(make_word(16'h0401, 48'h1, 16'h0001, 8'h01, ST_RUNNING, 1'b0));
    send_word(make_word(16'h0402, 48'h2, 16'h0200, 8'h02, jqps_pkg::ST_WAITING, 1'b0));
    send_word(make_word(16'h0403, 48'h3, 16'h0300, 8'h03, jqps_pkg::ST_WAITING, 1'b0));
    send_word(make_word(16'h0404, 48'h4, 16'h0400, 8'h04, jqps_pkg::ST_WAITING, 1'b1));
    settle();
  endtask

  // fill the store, then offer words that must be dropped; the dropped
  // closing word still starts the sort of the full list
  task automatic test_full_store();
    int k;
    write_policy(2'($urandom_range(0, 2)));
    for (k = 0; k < JOB_SLOTS + 2; k++) begin
      send_word(random_record(1'b0, k[0]));
    end
    send_word(random_record(1'b1, 1'b0));
    settle();
  endtask

  // receiver holds off for a long stretch while the sender keeps offering
  // a second list, so the input backs up behind the first one's results
  task automatic test_receiver_hold();
    write_policy(jqps_pkg::POL_ARRIVAL);
    tx_quiet = 1'b1;
    hold_requests++;
    send_random_list(6, 1'b0);
    send_random_list(5, 1'b1);
    tx_quiet = 1'b0;
    settle();
  endtask

  // random lists, mostly short, with policy changes and sender pauses between them
  task automatic test_random_lists(input int budget);
    int sent;
    int len;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 3) == 0) begin
        settle();
        write_policy(2'($urandom_range(0, 3)));
      end
      tx_quiet = ($urandom_range(0, 4) == 0);
      len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(9, 20);
      send_random_list(len, $urandom_range(0, 2) == 0);
      sent += len;
      if ($urandom_range(0, 4) == 0) begin
        settle();
      end
    end
    tx_quiet = 1'b0;
    settle();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_single_records();
    test_arrival_order();
    test_cpu_order();
    test_priority_order();
    test_keep_order();
    test_busy_head();
    test_full_store();
    test_receiver_hold();
    test_random_lists(50);
    // let any stray word show up before the verdict
    repeat (40) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
